// ===== rtl/core/pwsh_pkg.sv =====
// Shared types and constants for the position weighted string hash core.
// No dependencies; used by pwsh_div, pwsh_term and the top level.
`timescale 1ns / 1ps

package pwsh_pkg;

  localparam int POS_BITS  = 16;
  localparam int LEN_BITS  = 16;
  localparam int HASH_BITS = 64;
  localparam int DVD_BITS  = 64;
  localparam int CNT_BITS  = $clog2(DVD_BITS);

  localparam logic [13:0] K_OFFS   = 14'd9973;
  localparam logic [31:0] K_XOR    = 32'd67;
  localparam logic [31:0] K_ADD    = 32'd71;
  localparam logic [DVD_BITS-1:0] K_REM_DVD = DVD_BITS'(28657);

  localparam logic VARIANT_POLY  = 1'b0;
  localparam logic VARIANT_SHIFT = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic prep;
    logic mul;
    logic sum;
  } term_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_SUM  = 5'b01000,
    S_ACC  = 5'b10000
  } state_t;

endpackage

// ===== rtl/core/pwsh_div.sv =====
// Bit-serial restoring remainder unit: 64-bit dividend, 16-bit divisor.
// One dividend bit per cycle. Depends on pwsh_pkg.
`timescale 1ns / 1ps

module pwsh_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [pwsh_pkg::DVD_BITS-1:0]     dividend,
  input  logic [pwsh_pkg::POS_BITS-1:0]     divisor,
  output logic [pwsh_pkg::POS_BITS-1:0]     remainder,
  output pwsh_pkg::div_stat_t               stat
);

  logic [pwsh_pkg::DVD_BITS-1:0] dvd;
  logic [pwsh_pkg::POS_BITS-1:0] dvs;
  logic [pwsh_pkg::CNT_BITS-1:0] cnt;
  logic                          busy;
  logic                          done;
  logic [pwsh_pkg::POS_BITS:0]   trial;
  logic                          fits;

  assign trial = {remainder, dvd[pwsh_pkg::DVD_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so the trial fits after one subtract
  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      if (fits) begin
        remainder <= pwsh_pkg::POS_BITS'(trial - {1'b0, dvs});
      end else begin
        remainder <= trial[pwsh_pkg::POS_BITS-1:0];
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/core/pwsh_term.sv =====
// Per-byte term datapath: products, shifted term and polynomial term, one
// register rank per step. Depends on pwsh_pkg.
`timescale 1ns / 1ps

module pwsh_term (
  input  logic                              clk,
  input  pwsh_pkg::term_ctl_t               ctl,
  input  logic                              variant,
  input  logic [7:0]                        cval,
  input  logic [pwsh_pkg::POS_BITS-1:0]     n,
  input  logic [pwsh_pkg::POS_BITS-1:0]     r,
  input  logic [6:0]                        crem,
  output logic [pwsh_pkg::HASH_BITS-1:0]    term
);

  logic signed [7:0]  c_s;
  logic signed [8:0]  cp7;
  logic signed [16:0] cc7;
  logic signed [17:0] cc7_x;
  logic [13:0]        offs;

  logic signed [17:0] k5;
  logic [29:0]        m1;
  logic signed [34:0] p0;
  logic signed [24:0] p1;
  logic [31:0]        v;
  logic [pwsh_pkg::POS_BITS-1:0] sh;
  logic [31:0]        base;

  assign c_s   = $signed(cval);
  assign cp7   = $signed({cval[7], cval}) + 9'sd7;
  assign cc7   = c_s * cp7;
  assign cc7_x = {cc7[16], cc7};
  assign offs  = pwsh_pkg::K_OFFS + {{6{cval[7]}}, cval};
  assign base  = ({2'b00, m1} - {{24{cval[7]}}, cval}) ^ pwsh_pkg::K_XOR;

  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      k5 <= (cc7_x <<< 2) + cc7_x;
      m1 <= n * offs;
    end
    if (ctl.mul) begin
      p0 <= $signed({1'b0, n}) * k5;
      p1 <= c_s * $signed({1'b0, r});
      v  <= base + {25'd0, crem} + pwsh_pkg::K_ADD;
      sh <= r;
    end
    if (ctl.sum) begin
      if (variant == pwsh_pkg::VARIANT_SHIFT) begin
        // shift of 64 or more clears the term
        if (|sh[pwsh_pkg::POS_BITS-1:6]) begin
          term <= '0;
        end else begin
          term <= {32'd0, v} << sh[5:0];
        end
      end else begin
        term <= {{29{p0[34]}}, p0} + {{39{p1[24]}}, p1};
      end
    end
  end

endmodule

// ===== rtl/core/position_weighted_string_hash_core.sv =====
// Top level of the position weighted string hash: sequencer, accumulator,
// position counter and result register. Uses pwsh_pkg, pwsh_div, pwsh_term.
`timescale 1ns / 1ps
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------
//  in        in_valid / in_stall       key_byte[7:0], last_byte
//  out       out_valid / out_stall     hash_value[63:0], key_length[15:0]
//  cfg       cfg_valid / cfg_ready     cfg_data (variant)
//
// Each byte runs from acceptance through the bit-serial c mod n remainder, a
// step that hands the remainder over, then the products, term and accumulate
// steps, one register rank each, before the next byte can be accepted.
// rst is synchronous: accumulator and position clear, variant returns to 1.
// A finished hash waits in the result register; only a last byte that finds
// it still stalled holds in the accumulate step.

module position_weighted_string_hash_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          key_byte,
  input  logic                                last_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pwsh_pkg::HASH_BITS-1:0]      hash_value,
  output logic [pwsh_pkg::LEN_BITS-1:0]       key_length,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data
);

  pwsh_pkg::state_t                 state;
  pwsh_pkg::div_stat_t              mod_stat;
  pwsh_pkg::div_stat_t              rem_stat;
  pwsh_pkg::term_ctl_t              tctl;

  logic                             variant;
  logic [pwsh_pkg::HASH_BITS-1:0]   acc;
  logic [pwsh_pkg::POS_BITS-1:0]    position;
  logic [pwsh_pkg::POS_BITS-1:0]    position_next;
  logic [7:0]                       cval;
  logic                             last;
  logic                             accept;
  logic                             out_free;
  logic                             load_out;
  logic [pwsh_pkg::POS_BITS-1:0]    r;
  logic [pwsh_pkg::POS_BITS-1:0]    crem_raw;
  logic [6:0]                       crem;
  logic [pwsh_pkg::POS_BITS-1:0]    abs_c;
  logic [7:0]                       neg_c;
  logic [pwsh_pkg::HASH_BITS-1:0]   term;
  logic [pwsh_pkg::HASH_BITS-1:0]   acc_next;

  assign in_stall  = (state != pwsh_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign load_out  = (state == pwsh_pkg::S_ACC) && last && out_free;

  assign position_next = (position == '1) ? position : position + 1'b1;
  assign neg_c         = 8'd0 - key_byte;
  assign abs_c         = key_byte[7] ? {8'd0, neg_c} : {8'd0, key_byte};
  // truncating remainder of a positive dividend: zero byte adds nothing
  assign crem          = (cval == 8'd0) ? 7'd0 : crem_raw[6:0];
  assign acc_next      = acc + term;

  assign tctl.prep = (state == pwsh_pkg::S_DIV);
  assign tctl.mul  = (state == pwsh_pkg::S_MUL);
  assign tctl.sum  = (state == pwsh_pkg::S_SUM);

  pwsh_div u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  ({{(pwsh_pkg::DVD_BITS-8){key_byte[7]}}, key_byte}),
    .divisor   (position_next),
    .remainder (r),
    .stat      (mod_stat)
  );

  pwsh_div u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (pwsh_pkg::K_REM_DVD),
    .divisor   (abs_c),
    .remainder (crem_raw),
    .stat      (rem_stat)
  );

  pwsh_term u_term (
    .clk     (clk),
    .ctl     (tctl),
    .variant (variant),
    .cval    (cval),
    .n       (position),
    .r       (r),
    .crem    (crem),
    .term    (term)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pwsh_pkg::S_IDLE;
      variant   <= pwsh_pkg::VARIANT_SHIFT;
      acc       <= '0;
      position  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        variant <= cfg_data;
      end
      // a new hash replaces the one leaving in the same cycle
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        pwsh_pkg::S_IDLE: begin
          if (accept) begin
            position <= position_next;
            state    <= pwsh_pkg::S_DIV;
          end
        end
        pwsh_pkg::S_DIV: begin
          // both units start together, so they finish together
          if (mod_stat.done && !rem_stat.busy) begin
            state <= pwsh_pkg::S_MUL;
          end
        end
        pwsh_pkg::S_MUL: begin
          state <= pwsh_pkg::S_SUM;
        end
        pwsh_pkg::S_SUM: begin
          state <= pwsh_pkg::S_ACC;
        end
        pwsh_pkg::S_ACC: begin
          if (!last) begin
            acc   <= acc_next;
            state <= pwsh_pkg::S_IDLE;
          end else if (out_free) begin
            acc      <= '0;
            position <= '0;
            state    <= pwsh_pkg::S_IDLE;
          end
        end
        default: begin
          state <= pwsh_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cval <= key_byte;
      last <= last_byte;
    end
    if (load_out) begin
      hash_value <= acc_next;
      key_length <= pwsh_pkg::LEN_BITS'(position);
    end
  end

endmodule

// ===== tb/position_weighted_string_hash_core_tb.sv =====
// Self-checking testbench for position_weighted_string_hash_core: a queue-fed
// byte driver, a scoreboard that predicts each key's hash, and random stalls.
// Depends on pwsh_pkg and the core RTL only.
`timescale 1ns / 1ps

module position_weighted_string_hash_core_tb;

  typedef struct {
    logic [7:0] key_byte;
    logic       last_byte;
  } key_beat_t;

  typedef struct {
    logic [pwsh_pkg::HASH_BITS-1:0] hash_value;
    logic [pwsh_pkg::LEN_BITS-1:0]  key_length;
  } key_hash_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     key_byte = '0;
  logic                           last_byte = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [pwsh_pkg::HASH_BITS-1:0] hash_value;
  logic [pwsh_pkg::LEN_BITS-1:0]  key_length;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic                           cfg_data = 1'b0;

  key_beat_t key_beat_q[$];
  key_hash_t hash_expect_q[$];

  // sender / receiver behaviour, set per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  logic                in_fire = 1'b0;
  int unsigned         bytes_queued = 0;
  int unsigned         bytes_taken = 0;
  int unsigned         hashes_checked = 0;
  int unsigned         cfg_writes = 0;
  int unsigned         longest_key = 0;
  int unsigned         mismatch_count = 0;

  // predictor state
  logic                          hash_variant = pwsh_pkg::VARIANT_SHIFT;
  logic [63:0]                   hash_acc = '0;
  logic [pwsh_pkg::POS_BITS-1:0] hash_pos = '0;

  position_weighted_string_hash_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .key_byte   (key_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value),
    .key_length (key_length),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Contribution of one byte at 1-based position n.
  function automatic logic [63:0] key_term(input logic [7:0] b,
                                           input logic [pwsh_pkg::POS_BITS-1:0] n,
                                           input logic sel);
    logic [63:0] c;
    logic [63:0] nn;
    logic [63:0] r;
    logic [63:0] base;
    logic [63:0] rem_t;
    int          sc;
    c = {{56{b[7]}}, b};
    nn = 64'(n);
    r = c % nn;
    sc = int'($signed(b));
    if (sel == pwsh_pkg::VARIANT_POLY)
      return nn * c * (64'd7 + c) * 64'd5 + c * r;
    base = (nn * (64'd9973 + c) - c) ^ 64'd67;
    // divide by zero byte: rem term counts as nothing
    rem_t = (sc != 0) ? 64'(28657 % sc) : 64'd0;
    if (r >= 64)
      return 64'd0;
    return (base + rem_t + 64'd71) << r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Sender: hold a stalled beat, otherwise fetch the next one or idle.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (key_beat_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        key_beat_t nb;
        nb = key_beat_q.pop_front();
        in_valid  <= 1'b1;
        key_byte  <= nb.key_byte;
        last_byte <= nb.last_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: long hold-off when requested, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor and scoreboard.
  always @(posedge clk) begin
    in_fire <= in_valid && !in_stall && !rst;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (hash_expect_q.size() == 0) begin
          report_mismatch("unexpected hash beat", hash_value, 64'd0);
        end else begin
          key_hash_t e;
          e = hash_expect_q.pop_front();
          if (hash_value !== e.hash_value)
            report_mismatch("hash_value", hash_value, e.hash_value);
          if (key_length !== e.key_length)
            report_mismatch("key_length", 64'(key_length), 64'(e.key_length));
          hashes_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        key_hash_t hx;
        bytes_taken++;
        if (hash_pos != {pwsh_pkg::POS_BITS{1'b1}})
          hash_pos = hash_pos + 1'b1;
        hash_acc = hash_acc + key_term(key_byte, hash_pos, hash_variant);
        if (last_byte) begin
          if (hash_pos > longest_key)
            longest_key = hash_pos;
          hx.hash_value = hash_acc;
          hx.key_length = pwsh_pkg::LEN_BITS'(hash_pos);
          hash_expect_q.insert(hash_expect_q.size(), hx);
          hash_acc = '0;
          hash_pos = '0;
        end
      end
      if (cfg_valid && cfg_ready) begin
        hash_variant = cfg_data;
        cfg_writes++;
      end
    end
  end

  function automatic logic [7:0] pick_key_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'h80;
      2: return 8'hFF;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_key(input logic [7:0] bytes[$]);
    key_beat_t kb;
    foreach (bytes[i]) begin
      kb.key_byte  = bytes[i];
      kb.last_byte = (i == bytes.size() - 1);
      key_beat_q.insert(key_beat_q.size(), kb);
    end
    bytes_queued += bytes.size();
  endtask

  task automatic push_random_key(input int unsigned len);
    logic [7:0] bytes[$];
    repeat (len) bytes.insert(bytes.size(), pick_key_byte());
    push_key(bytes);
  endtask

  // Mostly short keys; some long enough for large shift counts.
  task automatic push_random_phase(input int unsigned target);
    int unsigned start;
    int unsigned sel;
    start = bytes_queued;
    push_random_key(80);
    while (bytes_queued - start < target) begin
      sel = $urandom_range(99);
      if (sel < 85)
        push_random_key($urandom_range(1, 6));
      else if (sel < 95)
        push_random_key($urandom_range(7, 40));
      else
        push_random_key($urandom_range(41, 150));
    end
  endtask

  // Wait for every byte to be taken and every hash to arrive, then let
  // the core finish any byte still in flight.
  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_taken != bytes_queued || hash_expect_q.size() != 0);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_variant(input logic v);
    int unsigned n0;
    wait_idle();
    n0 = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk);
    while (cfg_writes == n0);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed keys, reset variant (shifted formula)
    set_idling(0, 0);
    push_key('{8'h00});
    push_key('{8'h7F});
    push_key('{8'h80});
    push_key('{8'hFF});
    push_key('{8'h01});
    push_key('{8'h05, 8'hFE, 8'h80, 8'h00, 8'h7F});
    push_key('{8'hFF, 8'hFF});

    // directed keys, polynomial formula
    write_variant(pwsh_pkg::VARIANT_POLY);
    set_idling(0, 0);
    push_key('{8'h80});
    push_key('{8'h7F});
    push_key('{8'hFF, 8'h00, 8'h80, 8'h7F});
    push_key('{8'h00});

    // random phases across the idling mixes
    write_variant(pwsh_pkg::VARIANT_SHIFT);
    set_idling(0, 0);
    push_random_phase(200);
    write_variant(pwsh_pkg::VARIANT_POLY);
    set_idling(80, 0);
    push_random_phase(200);
    write_variant(pwsh_pkg::VARIANT_SHIFT);
    set_idling(0, 80);
    push_random_phase(200);
    write_variant(pwsh_pkg::VARIANT_POLY);
    set_idling(14, 14);
    push_random_phase(200);

    // back-pressure: receiver holds off while short keys keep coming
    write_variant(pwsh_pkg::VARIANT_SHIFT);
    set_idling(0, 0);
    hold_req = 3000;
    repeat (40) push_random_key($urandom_range(1, 2));
    wait_idle();
    set_idling(14, 14);
    repeat (20) push_random_key($urandom_range(1, 4));
    wait_idle();

    $display("covered %0d bytes, %0d hashes checked, longest key %0d bytes",
             bytes_taken, hashes_checked, longest_key);
    $display("both formulas, %0d variant writes, idle/stall mixes and a long output hold",
             cfg_writes);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout after %0d bytes, %0d hashes", bytes_taken, hashes_checked);
    $display("FAILURE");
    $finish;
  end

endmodule
